// ----- rtl/core/plzt_pkg.sv -----
// Shared types, token codes and character tables for the PL/0 token scanner.
// Used by the scan core, the result queue, the top level and the checker.
package plzt_pkg;

  // Token codes.
  localparam logic [5:0] TokInvalid = 6'd0;
  localparam logic [5:0] TokIdent   = 6'd1;
  localparam logic [5:0] TokNumber  = 6'd2;
  localparam logic [5:0] TokKwBase  = 6'd3;
  localparam logic [5:0] TokPlus    = 6'd19;
  localparam logic [5:0] TokMinus   = 6'd20;
  localparam logic [5:0] TokStar    = 6'd21;
  localparam logic [5:0] TokSlash   = 6'd22;
  localparam logic [5:0] TokEq      = 6'd23;
  localparam logic [5:0] TokNe      = 6'd24;
  localparam logic [5:0] TokLt      = 6'd25;
  localparam logic [5:0] TokLe      = 6'd26;
  localparam logic [5:0] TokGt      = 6'd27;
  localparam logic [5:0] TokGe      = 6'd28;
  localparam logic [5:0] TokLParen  = 6'd29;
  localparam logic [5:0] TokRParen  = 6'd30;
  localparam logic [5:0] TokComma   = 6'd31;
  localparam logic [5:0] TokSemi    = 6'd32;
  localparam logic [5:0] TokPeriod  = 6'd33;
  localparam logic [5:0] TokAssign  = 6'd34;
  localparam logic [5:0] TokAndAnd  = 6'd35;
  localparam logic [5:0] TokOrOr    = 6'd36;
  localparam logic [5:0] TokNot     = 6'd37;
  localparam logic [5:0] TokLBrack  = 6'd38;
  localparam logic [5:0] TokRBrack  = 6'd39;
  localparam logic [5:0] TokLBrace  = 6'd40;
  localparam logic [5:0] TokRBrace  = 6'd41;
  localparam logic [5:0] TokEnd     = 6'd42;

  localparam int KwCount = 16;

  // Character constants.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;

  // Result queue geometry.
  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 3;

  typedef enum logic [2:0] {
    PhIdle,
    PhIdent,
    PhNumber,
    PhSlash,
    PhSym,
    PhBlock,
    PhLine
  } scan_phase_e;

  typedef struct packed {
    logic [5:0]  code;
    logic [29:0] value;
    logic [63:0] text;
    logic [3:0]  len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  // Which of the two token slots carry a token in this cycle.
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

  // Keyword spellings, first character in the low byte. The third one has
  // nine characters; only its first eight are held, so it never matches.
  localparam logic [63:0] KwText [KwCount] = '{
    64'h0000_0000_0072_6176, 64'h0000_0074_736E_6F63, 64'h7275_6465_636F_7270,
    64'h0000_006E_6967_6562, 64'h0000_0000_0064_6E65, 64'h0000_0000_0000_6669,
    64'h0000_0000_6E65_6874, 64'h0000_0000_0000_6F64, 64'h0000_0065_6C69_6877,
    64'h0000_0000_6C6C_6163, 64'h0000_0000_0064_646F, 64'h0000_6E72_7574_6572,
    64'h0000_0000_6573_6C65, 64'h0000_0000_6669_6C65, 64'h0000_0066_6964_6E65,
    64'h0000_0074_6E69_7270
  };

  localparam logic [4:0] KwLen [KwCount] = '{
    5'd3, 5'd5, 5'd9, 5'd5, 5'd3, 5'd2, 5'd4, 5'd2,
    5'd5, 5'd4, 5'd3, 5'd6, 5'd4, 5'd4, 5'd5, 5'd5
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return is_alpha(c) || c == ChUnder;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  // Characters that may begin a two-character symbol.
  function automatic logic starts_pair(input logic [7:0] c);
    return c == "!" || c == "<" || c == ">" || c == ":" || c == "&" || c == "|";
  endfunction

  // One-character symbol code, invalid when the character is no symbol.
  function automatic logic [5:0] sym_single(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = TokPlus;
      "-":     k = TokMinus;
      "*":     k = TokStar;
      "/":     k = TokSlash;
      "=":     k = TokEq;
      "<":     k = TokLt;
      ">":     k = TokGt;
      "(":     k = TokLParen;
      ")":     k = TokRParen;
      ",":     k = TokComma;
      ";":     k = TokSemi;
      ".":     k = TokPeriod;
      "!":     k = TokNot;
      "[":     k = TokLBrack;
      "]":     k = TokRBrack;
      "{":     k = TokLBrace;
      "}":     k = TokRBrace;
      default: k = TokInvalid;
    endcase
    return k;
  endfunction

  // Two-character symbol code, invalid when the pair forms none.
  function automatic logic [5:0] sym_pair(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = TokInvalid;
    if (a == "!" && b == "=") k = TokNe;
    if (a == "<" && b == "=") k = TokLe;
    if (a == ">" && b == "=") k = TokGe;
    if (a == ":" && b == "=") k = TokAssign;
    if (a == "&" && b == "&") k = TokAndAnd;
    if (a == "|" && b == "|") k = TokOrOr;
    return k;
  endfunction

  // Keyword code for the buffered word, invalid when it is no keyword.
  // Bytes past the word length are zero, so the whole word is compared.
  function automatic logic [5:0] kw_lookup(input logic [63:0] text, input logic [4:0] len);
    logic [5:0] k;
    k = TokInvalid;
    for (int i = 0; i < KwCount; i++) begin
      if (len == KwLen[i] && text == KwText[i]) k = TokKwBase + 6'(i);
    end
    return k;
  endfunction

  function automatic token_t mk_tok(input logic [5:0] code, input logic [15:0] line,
                                    input logic [15:0] col);
    token_t t;
    t      = '0;
    t.code = code;
    t.line = line;
    t.col  = col;
    return t;
  endfunction

endpackage

// ----- rtl/core/plzt_scan_core.sv -----
// Scanner state and token decode: one character per cycle while in_fire_i is set, up to two tokens.
// Depends on plzt_pkg for character classes, symbol and keyword tables.
module plzt_scan_core
  import plzt_pkg::*;
#(
  parameter int ID_MAX_LEN     = 8,
  parameter int NUM_MAX_DIGITS = 9,
  parameter int POS_BITS       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       in_mode_i,
  input  logic [7:0] in_char_i,
  output push_t      push_o,
  output token_t     tok_a_o,
  output token_t     tok_b_o
);

  localparam int ExtW = (POS_BITS > 16) ? POS_BITS : 16;

  scan_phase_e         phase_q, phase_d;
  logic [63:0]         text_q, text_d;
  logic [4:0]          count_q, count_d;
  logic [29:0]         accum_q, accum_d;
  logic                bad_q, bad_d;
  logic [7:0]          held_q, held_d;
  logic                star_q, star_d;
  logic [POS_BITS-1:0] line_q, line_d;
  logic [POS_BITS-1:0] col_q, col_d;
  logic [POS_BITS-1:0] tok_line_q, tok_line_d;
  logic [POS_BITS-1:0] tok_col_q, tok_col_d;

  logic [ExtW-1:0] line_ext, col_ext, tok_line_ext, tok_col_ext;
  logic [15:0]     ln16, col16, tln16, tcol16;
  logic [7:0]      c;
  logic            restart;
  logic            fresh;
  logic [5:0]      pair_code;
  token_t          ident_tok, number_tok, held_tok;

  assign c            = in_char_i;
  assign line_ext     = ExtW'(line_q);
  assign col_ext      = ExtW'(col_q);
  assign tok_line_ext = ExtW'(tok_line_q);
  assign tok_col_ext  = ExtW'(tok_col_q);
  assign ln16         = line_ext[15:0];
  assign col16        = col_ext[15:0];
  assign tln16        = tok_line_ext[15:0];
  assign tcol16       = tok_col_ext[15:0];

  // A NUL after a held one-character symbol completes that symbol and is
  // consumed with it.
  assign pair_code    = (c == ChNul) ? sym_single(held_q) : sym_pair(held_q, c);

  // A character that begins no token and is no blank is a token by itself.
  assign fresh = !is_white(c) && !is_ident_start(c) && !is_digit(c) &&
                 c != ChSlash && !starts_pair(c);

  // The pending token ends here and the character is scanned afresh.
  always_comb begin
    restart = 1'b0;
    case (phase_q)
      PhIdent:  restart = !is_ident_char(c);
      PhNumber: restart = !is_digit(c) && !is_ident_start(c);
      PhSlash:  restart = c != ChStar && c != ChSlash;
      PhSym:    restart = pair_code == TokInvalid;
      PhBlock:  restart = 1'b0;
      PhLine:   restart = 1'b0;
      default:  restart = 1'b1;
    endcase
  end

  always_comb begin
    token_t t;
    t = mk_tok(TokInvalid, tln16, tcol16);
    if (count_q <= 5'(ID_MAX_LEN)) begin
      t.code = kw_lookup(text_q, count_q);
      if (t.code == TokInvalid) begin
        t.code = TokIdent;
        t.text = text_q;
        t.len  = count_q[3:0];
      end
    end
    ident_tok = t;
  end

  always_comb begin
    number_tok = mk_tok(TokInvalid, tln16, tcol16);
    if (!bad_q && count_q <= 5'(NUM_MAX_DIGITS)) begin
      number_tok.code  = TokNumber;
      number_tok.value = accum_q;
    end
  end

  assign held_tok = mk_tok(sym_single(held_q), tln16, tcol16);

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    text_d     = text_q;
    count_d    = count_q;
    accum_d    = accum_q;
    bad_d      = bad_q;
    held_d     = held_q;
    star_d     = star_q;
    line_d     = line_q;
    col_d      = col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    if (in_fire_i) begin
      if (in_mode_i) begin
        phase_d    = PhIdle;
        text_d     = '0;
        count_d    = '0;
        accum_d    = '0;
        bad_d      = 1'b0;
        held_d     = '0;
        star_d     = 1'b0;
        line_d     = POS_BITS'(1);
        col_d      = '0;
        tok_line_d = POS_BITS'(1);
        tok_col_d  = '0;
      end else begin
        if (c == ChLf) begin
          if (line_q != '1) line_d = line_q + POS_BITS'(1);
          col_d = '0;
        end else if (col_q != '1) begin
          col_d = col_q + POS_BITS'(1);
        end

        case (phase_q)
          PhIdent: begin
            if (is_ident_char(c)) begin
              if (count_q < 5'(ID_MAX_LEN)) text_d[{count_q[2:0], 3'b000} +: 8] = c;
              if (count_q != 5'd31) count_d = count_q + 5'd1;
            end
          end
          PhNumber: begin
            if (is_digit(c)) begin
              if (count_q < 5'(NUM_MAX_DIGITS)) begin
                accum_d = 30'(33'({accum_q, 3'b000}) + 33'({accum_q, 1'b0}) +
                              33'(c[3:0]));
              end
              if (count_q != 5'd31) count_d = count_q + 5'd1;
            end else if (is_ident_start(c)) begin
              bad_d = 1'b1;
            end
          end
          PhSlash: begin
            if (c == ChStar) begin
              star_d  = 1'b0;
              phase_d = PhBlock;
            end else if (c == ChSlash) begin
              phase_d = PhLine;
            end
          end
          PhSym: begin
            if (pair_code != TokInvalid) phase_d = PhIdle;
          end
          PhBlock: begin
            // A star directly followed by a slash closes the comment.
            if (star_q && c == ChSlash) phase_d = PhIdle;
            else star_d = (c == ChStar);
          end
          PhLine: begin
            if (c == ChLf) phase_d = PhIdle;
          end
          default: begin
          end
        endcase

        if (restart) begin
          phase_d    = PhIdle;
          tok_line_d = line_q;
          tok_col_d  = col_q;
          if (is_ident_start(c)) begin
            text_d  = {56'd0, c};
            count_d = 5'd1;
            phase_d = PhIdent;
          end else if (is_digit(c)) begin
            accum_d = 30'(c[3:0]);
            bad_d   = 1'b0;
            count_d = 5'd1;
            phase_d = PhNumber;
          end else if (c == ChSlash) begin
            phase_d = PhSlash;
          end else if (starts_pair(c)) begin
            held_d  = c;
            phase_d = PhSym;
          end
        end
      end
    end
  end

  // Tokens of this item: slot a finishes the pending token, slot b is the
  // end token or a token that the character makes on its own.
  always_comb begin
    push_o  = '0;
    tok_a_o = ident_tok;
    tok_b_o = mk_tok(TokEnd, ln16, col16);
    if (in_fire_i) begin
      case (phase_q)
        PhIdent:  tok_a_o = ident_tok;
        PhNumber: tok_a_o = number_tok;
        PhSlash:  tok_a_o = mk_tok(TokSlash, tln16, tcol16);
        PhSym: begin
          if (!in_mode_i && pair_code != TokInvalid) tok_a_o = mk_tok(pair_code, tln16, tcol16);
          else tok_a_o = held_tok;
        end
        default:  tok_a_o = ident_tok;
      endcase
      if (in_mode_i) begin
        push_o.a = phase_q == PhIdent || phase_q == PhNumber ||
                   phase_q == PhSlash || phase_q == PhSym;
        push_o.b = 1'b1;
      end else begin
        push_o.a = phase_q == PhSym ||
                   (restart && (phase_q == PhIdent || phase_q == PhNumber ||
                                phase_q == PhSlash));
        push_o.b = restart && fresh;
        tok_b_o  = mk_tok(sym_single(c), ln16, col16);
      end
      tok_a_o.last = !push_o.b;
      tok_b_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      text_q     <= '0;
      count_q    <= '0;
      accum_q    <= '0;
      bad_q      <= 1'b0;
      held_q     <= '0;
      star_q     <= 1'b0;
      line_q     <= POS_BITS'(1);
      col_q      <= '0;
      tok_line_q <= POS_BITS'(1);
      tok_col_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      text_q     <= text_d;
      count_q    <= count_d;
      accum_q    <= accum_d;
      bad_q      <= bad_d;
      held_q     <= held_d;
      star_q     <= star_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
    end
  end

endmodule

// ----- rtl/core/plzt_out_fifo.sv -----
// Result queue: takes up to two tokens a cycle, delivers one a cycle while out_ready_i is high.
// Depends on plzt_pkg for the token and push types.
module plzt_out_fifo
  import plzt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  token_t tok_a_i,
  input  token_t tok_b_i,
  output logic   space_o,
  output logic   out_valid_o,
  output token_t out_tok_o,
  input  logic   out_ready_i
);

  token_t             mem_q [OutDepth];
  logic [OutPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic [OutPtrW-1:0] widx_b;
  logic [OutCntW-1:0] n_push;
  logic               pop;

  // Room for two tokens, the most that one item can bring.
  assign space_o     = cnt_q <= OutCntW'(OutDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_tok_o   = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = OutCntW'(push_i.a) + OutCntW'(push_i.b);
  assign widx_b      = push_i.a ? wptr_q + OutPtrW'(1) : wptr_q;
  assign wptr_d      = wptr_q + n_push[OutPtrW-1:0];
  assign rptr_d      = pop ? rptr_q + OutPtrW'(1) : rptr_q;
  assign cnt_d       = cnt_q + n_push - OutCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.a) mem_q[wptr_q] <= tok_a_i;
    if (push_i.b) mem_q[widx_b] <= tok_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/pl_zero_token_scanner.sv -----
// Top level of the PL/0 token scanner: stream ports, scan core, result queue.
// Depends on plzt_pkg, plzt_scan_core and plzt_out_fifo.
//
// The slave channel takes one source character per item; tuser set marks
// the end of input, and tdata is then ignored. The master channel gives
// one token per item with its start line and column; tlast marks the last
// token that one input item causes. An end item flushes any pending token,
// emits the end token and returns the scanner to its reset state.
// A character item is taken in every cycle while s_axis_tready_o is high;
// the decode runs in the cycle of acceptance and fills the result queue.
// One item makes at most two tokens, and the master port delivers one per
// cycle, so runs of two-token items are paced by that port through the
// four-entry result queue: s_axis_tready_o drops while more than two tokens
// wait. When the receiver stalls, the queue fills and the input is held
// off; nothing is lost or repeated. Reset empties the queue and sets the
// scanner idle at line 1, column 0.
module pl_zero_token_scanner
  import plzt_pkg::*;
#(
  parameter int ID_MAX_LEN     = 8,
  parameter int NUM_MAX_DIGITS = 9,
  parameter int POS_BITS       = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // char_code[7:0]
  input  logic         s_axis_tuser_i,  // mode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // token_code[5:0], number_value[35:6], ident_text[99:36], ident_length[103:100],
  // start_line[119:104], start_column[135:120]
  output logic [135:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o   // last
);

  push_t  push;
  token_t tok_a, tok_b, out_tok;
  logic   in_fire;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  plzt_scan_core #(
    .ID_MAX_LEN    (ID_MAX_LEN),
    .NUM_MAX_DIGITS(NUM_MAX_DIGITS),
    .POS_BITS      (POS_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_fire_i(in_fire),
    .in_mode_i(s_axis_tuser_i),
    .in_char_i(s_axis_tdata_i),
    .push_o   (push),
    .tok_a_o  (tok_a),
    .tok_b_o  (tok_b)
  );

  plzt_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .tok_a_i    (tok_a),
    .tok_b_i    (tok_b),
    .space_o    (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_tok_o  (out_tok),
    .out_ready_i(m_axis_tready_i)
  );

  assign m_axis_tdata_o = {out_tok.col, out_tok.line, out_tok.len, out_tok.text,
                           out_tok.value, out_tok.code};
  assign m_axis_tlast_o = out_tok.last;

endmodule

// ----- rtl/core/plzt_checker.sv -----
// Port-level checks on the token scanner's result stream, bound to the top.
// Depends on plzt_pkg for the token codes.
module plzt_checker
  import plzt_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o
);

  logic [5:0] code;
  assign code = m_axis_tdata_o[5:0];

  // Token codes stay within the defined set.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> code <= TokEnd)
    else $error("token code out of range");

  // Only identifiers carry text and a length.
  a_ident_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && code != TokIdent |-> m_axis_tdata_o[103:36] == '0)
    else $error("text on a token that is no identifier");

  // Only number tokens carry a value.
  a_number_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && code != TokNumber |-> m_axis_tdata_o[35:6] == '0)
    else $error("value on a token that is no number");

  // The end token is always the last token of its item.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && code == TokEnd |-> m_axis_tlast_o)
    else $error("end token without tlast");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result item changed");

endmodule

bind pl_zero_token_scanner plzt_checker u_checker (.*);

// ----- test/pl_zero_token_scanner_tb.sv -----
// Self-checking testbench for pl_zero_token_scanner: source characters go in on the
// slave stream, and every token that comes out is compared with a scanner model kept
// here. Depends on plzt_pkg and the RTL of the scanner.
`timescale 1ns / 1ps

module pl_zero_token_scanner_tb;
  import plzt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int IdMaxLen   = 8;
  localparam int NumMaxDig  = 9;
  localparam int SymCount   = 23;

  // Symbol spellings in code order; a zero trailing byte marks a single character.
  localparam logic [7:0] SymLead [SymCount] = '{
    "+", "-", "*", "/", "=", "!", "<", "<", ">", ">", "(", ")",
    ",", ";", ".", ":", "&", "|", "!", "[", "]", "{", "}"
  };
  localparam logic [7:0] SymTrail [SymCount] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "=", 8'h00, "=", 8'h00, "=", 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, "=", "&", "|", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = 8'h00;  // char_code[7:0]
  logic         s_axis_tuser_i  = 1'b0;   // mode
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // token_code[5:0], number_value[35:6], ident_text[99:36], ident_length[103:100],
  // start_line[119:104], start_column[135:120]
  logic [135:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;   // last

  pl_zero_token_scanner i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Scanner model state.
  scan_phase_e sc_phase;
  logic [7:0]  sc_word [IdMaxLen];
  int unsigned sc_count;
  logic [29:0] sc_acc;
  logic        sc_bad;
  logic [7:0]  sc_held;
  logic        sc_star;
  logic [15:0] sc_line, sc_col, sc_tok_line, sc_tok_col;

  token_t pending_tokens[$];

  int err_count;
  int cycle_count;
  int chars_sent;
  int ends_sent;
  int tokens_checked;
  int burst_left;
  int sink_style;
  int sink_left;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_start(input logic [7:0] c);
    return is_letter(c) || c == ChUnder;
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return word_start(c) || is_dec(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic string keyword_text(input int idx);
    case (idx)
      0:       return "var";
      1:       return "const";
      2:       return "procedure";
      3:       return "begin";
      4:       return "end";
      5:       return "if";
      6:       return "then";
      7:       return "do";
      8:       return "while";
      9:       return "call";
      10:      return "odd";
      11:      return "return";
      12:      return "else";
      13:      return "elif";
      14:      return "endif";
      default: return "print";
    endcase
  endfunction

  // A trailing byte of zero also matches a single-character symbol.
  function automatic logic [5:0] symbol_code(input logic [7:0] a, input logic [7:0] b);
    for (int i = 0; i < SymCount; i++) begin
      if (SymLead[i] == a && SymTrail[i] == b) return TokPlus + 6'(i);
    end
    return TokInvalid;
  endfunction

  function automatic logic opens_pair(input logic [7:0] c);
    for (int i = 0; i < SymCount; i++) begin
      if (SymLead[i] == c && SymTrail[i] != 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_token(input logic [5:0] code, input logic [29:0] value,
                                    input logic [63:0] text, input logic [3:0] len,
                                    input logic [15:0] line, input logic [15:0] col);
    token_t t;
    t       = '0;
    t.code  = code;
    t.value = value;
    t.text  = text;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    pending_tokens.push_back(t);
  endfunction

  function automatic void clear_scanner();
    sc_phase = PhIdle;
    foreach (sc_word[i]) sc_word[i] = 8'h00;
    sc_count    = 0;
    sc_acc      = '0;
    sc_bad      = 1'b0;
    sc_held     = 8'h00;
    sc_star     = 1'b0;
    sc_line     = 16'd1;
    sc_col      = 16'd0;
    sc_tok_line = 16'd1;
    sc_tok_col  = 16'd0;
  endfunction

  function automatic void word_token();
    logic [63:0] text;
    string       kw;
    logic        same;
    text = '0;
    if (sc_count > IdMaxLen) begin
      add_token(TokInvalid, '0, '0, '0, sc_tok_line, sc_tok_col);
      return;
    end
    for (int k = 0; k < KwCount; k++) begin
      kw = keyword_text(k);
      if (kw.len() == sc_count) begin
        same = 1'b1;
        for (int i = 0; i < kw.len(); i++) begin
          if (sc_word[i] != kw[i]) same = 1'b0;
        end
        if (same) begin
          add_token(TokKwBase + 6'(k), '0, '0, '0, sc_tok_line, sc_tok_col);
          return;
        end
      end
    end
    for (int i = 0; i < sc_count; i++) text |= 64'(sc_word[i]) << (8 * i);
    add_token(TokIdent, '0, text, 4'(sc_count), sc_tok_line, sc_tok_col);
  endfunction

  function automatic void number_token();
    if (sc_bad || sc_count > NumMaxDig) add_token(TokInvalid, '0, '0, '0, sc_tok_line, sc_tok_col);
    else add_token(TokNumber, sc_acc, '0, '0, sc_tok_line, sc_tok_col);
  endfunction

  // Scans a character with no token pending; it may open a token or emit one at once.
  function automatic void start_token(input logic [7:0] c, input logic [15:0] ln,
                                      input logic [15:0] col);
    sc_phase    = PhIdle;
    sc_tok_line = ln;
    sc_tok_col  = col;
    if (is_space(c)) return;
    if (word_start(c)) begin
      foreach (sc_word[i]) sc_word[i] = 8'h00;
      sc_word[0] = c;
      sc_count   = 1;
      sc_phase   = PhIdent;
    end else if (is_dec(c)) begin
      sc_acc   = 30'(c - 8'h30);
      sc_bad   = 1'b0;
      sc_count = 1;
      sc_phase = PhNumber;
    end else if (c == ChSlash) begin
      sc_phase = PhSlash;
    end else if (opens_pair(c)) begin
      sc_held  = c;
      sc_phase = PhSym;
    end else begin
      add_token(symbol_code(c, 8'h00), '0, '0, '0, ln, col);
    end
  endfunction

  function automatic void scan_item(input logic end_flag, input logic [7:0] c);
    int unsigned n0;
    logic [15:0] ln, col;
    logic [5:0]  k;
    n0  = pending_tokens.size();
    ln  = sc_line;
    col = sc_col;
    if (end_flag) begin
      case (sc_phase)
        PhIdent:  word_token();
        PhNumber: number_token();
        PhSlash:  add_token(TokSlash, '0, '0, '0, sc_tok_line, sc_tok_col);
        PhSym:    add_token(symbol_code(sc_held, 8'h00), '0, '0, '0, sc_tok_line, sc_tok_col);
        default:  ;
      endcase
      add_token(TokEnd, '0, '0, '0, ln, col);
      clear_scanner();
    end else begin
      if (c == ChLf) begin
        if (sc_line != 16'hFFFF) sc_line++;
        sc_col = 16'd0;
      end else if (sc_col != 16'hFFFF) begin
        sc_col++;
      end
      case (sc_phase)
        PhIdent: begin
          if (word_char(c)) begin
            if (sc_count < IdMaxLen) sc_word[sc_count] = c;
            if (sc_count < 31) sc_count++;
          end else begin
            word_token();
            start_token(c, ln, col);
          end
        end
        PhNumber: begin
          if (is_dec(c)) begin
            if (sc_count < NumMaxDig) sc_acc = sc_acc * 30'd10 + 30'(c - 8'h30);
            if (sc_count < 31) sc_count++;
          end else if (word_start(c)) begin
            sc_bad = 1'b1;
          end else begin
            number_token();
            start_token(c, ln, col);
          end
        end
        PhSlash: begin
          if (c == ChStar) begin
            sc_star  = 1'b0;
            sc_phase = PhBlock;
          end else if (c == ChSlash) begin
            sc_phase = PhLine;
          end else begin
            add_token(TokSlash, '0, '0, '0, sc_tok_line, sc_tok_col);
            start_token(c, ln, col);
          end
        end
        PhSym: begin
          k = symbol_code(sc_held, c);
          if (k != TokInvalid) begin
            add_token(k, '0, '0, '0, sc_tok_line, sc_tok_col);
            sc_phase = PhIdle;
          end else begin
            add_token(symbol_code(sc_held, 8'h00), '0, '0, '0, sc_tok_line, sc_tok_col);
            start_token(c, ln, col);
          end
        end
        PhBlock: begin
          if (sc_star && c == ChSlash) sc_phase = PhIdle;
          else sc_star = (c == ChStar);
        end
        PhLine: begin
          if (c == ChLf) sc_phase = PhIdle;
        end
        default: start_token(c, ln, col);
      endcase
    end
    if (pending_tokens.size() > n0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus

  task automatic put_item(input logic end_flag, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tuser_i  <= end_flag;
    do @(posedge clk_i); while (!s_axis_tready_o);
    scan_item(end_flag, ch);
    burst_left--;
    if (end_flag) ends_sent++;
    else chars_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(1'b0, s[i]);
  endtask

  task automatic put_end();
    put_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Holds the input off until every predicted token has been delivered.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_word_char(input logic first);
    int r;
    r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return ChUnder;
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_comment_char();
    case ($urandom_range(0, 6))
      0:       return ChStar;
      1:       return ChSlash;
      2:       return ChSpace;
      3:       return ChLf;
      4:       return 8'h00;
      5:       return "x";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // An over-long word and number, lone pair starters, a number with a tail, odd bytes, pair
  // starters followed by NUL, a slash that does not close a block comment, and an
  // end inside that comment.
  task automatic test_special_cases();
    put_text("abcdefghi:|9a");
    put_end();
    put_item(1'b0, 8'hFF);
    put_text("1234567890!");
    put_item(1'b0, 8'h00);
    put_text("<");
    put_item(1'b0, ChNul);
    put_text(":");
    put_item(1'b0, ChNul);
    put_text("/*/");
    put_end();
  endtask

  // Mostly well-formed source text with random content.
  task automatic test_token_stream(input int item_count);
    int stop_at, pick, len, idx;
    logic paused;
    stop_at = chars_sent + ends_sent + item_count;
    paused  = 1'b0;
    while (chars_sent + ends_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        put_text(keyword_text($urandom_range(0, KwCount - 1)));
      end else if (pick < 38) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) put_item(1'b0, rand_word_char(i == 0));
      end else if (pick < 53) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) put_item(1'b0, 8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0) begin
          put_item(1'b0, rand_word_char(1'b1));
          if ($urandom_range(0, 1) == 0) put_item(1'b0, 8'("0" + $urandom_range(0, 9)));
        end
      end else if (pick < 71) begin
        idx = $urandom_range(0, SymCount - 1);
        put_item(1'b0, SymLead[idx]);
        if (SymTrail[idx] != 8'h00 && $urandom_range(0, 3) != 0) put_item(1'b0, SymTrail[idx]);
      end else if (pick < 83) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0:       put_item(1'b0, ChSpace);
            1:       put_item(1'b0, ChTab);
            2:       put_item(1'b0, ChCr);
            default: put_item(1'b0, ChLf);
          endcase
        end
      end else if (pick < 89) begin
        put_text("/*");
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) put_item(1'b0, rand_comment_char());
        if ($urandom_range(0, 6) == 0) put_end();
        else put_text("*/");
      end else if (pick < 93) begin
        put_text("//");
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) put_item(1'b0, rand_comment_char());
        put_item(1'b0, ChLf);
      end else if (pick < 97) begin
        put_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        put_end();
      end
      if ($urandom_range(0, 1) == 0) put_item(1'b0, ($urandom_range(0, 4) == 0) ? ChLf : ChSpace);
      if (!paused && chars_sent + ends_sent > stop_at - item_count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Arbitrary bytes with an occasional end item.
  task automatic test_byte_noise(input int item_count);
    for (int i = 0; i < item_count; i++) begin
      if ($urandom_range(0, 24) == 0) put_end();
      else put_item(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Checking

  function automatic void note_diff(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want != got) begin
      err_count++;
      if (err_count <= 30)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function automatic void check_token(input logic [135:0] d, input logic last_bit);
    token_t want;
    if (pending_tokens.size() == 0) begin
      err_count++;
      if (err_count <= 30)
        $display("%0t: unexpected token, expected none, actual code %0d", $time, d[5:0]);
      return;
    end
    want = pending_tokens.pop_front();
    tokens_checked++;
    note_diff("token_code", 64'(want.code), 64'(d[5:0]));
    note_diff("number_value", 64'(want.value), 64'(d[35:6]));
    note_diff("ident_text", want.text, d[99:36]);
    note_diff("ident_length", 64'(want.len), 64'(d[103:100]));
    note_diff("start_line", 64'(want.line), 64'(d[119:104]));
    note_diff("start_column", 64'(want.col), 64'(d[135:120]));
    note_diff("last", 64'(want.last), 64'(last_bit));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles with %0d tokens outstanding.",
                 cycle_count, pending_tokens.size());
        $display("FAILED: results differ");
        $finish;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_token(m_axis_tdata_o, m_axis_tlast_o);
      if (sink_left == 0) begin
        sink_style = $urandom_range(0, 4);
        sink_left  = (sink_style == 4) ? $urandom_range(5, 40) : $urandom_range(20, 200);
      end
      sink_left--;
      case (sink_style)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready_i <= ($urandom_range(0, 9) < 3);
        3:       m_axis_tready_i <= (cycle_count % 4 == 0);
        default: m_axis_tready_i <= 1'b0;
      endcase
    end
  end

  initial begin
    err_count      = 0;
    cycle_count    = 0;
    chars_sent     = 0;
    ends_sent      = 0;
    tokens_checked = 0;
    burst_left     = 0;
    sink_style     = 0;
    sink_left      = 0;
    clear_scanner();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    wait_drained();
    test_token_stream(1150);
    wait_drained();
    test_byte_noise(270);
    put_end();
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d characters and %0d end items of keywords, names, numbers, symbols,",
             chars_sent, ends_sent);
    $display("comments and raw bytes; %0d tokens were checked.", tokens_checked);
    if (err_count == 0 && pending_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
